// File: src/vmt_pkg.sv
// shared types and constants for the 4x4 vertex transform engine
package vmt_pkg;

    localparam int DIM      = 4;
    localparam int ENTRIES  = DIM * DIM;
    localparam int IDX_W    = 4;
    localparam int DW       = 32;
    localparam int PW       = 2 * DW;
    localparam int PAIR_W   = PW + 1;
    localparam int SUM_W    = PW + 2;

    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_TRANSFORM = 1'b1;

    typedef logic signed [DW-1:0]     t_word;
    typedef logic signed [PW-1:0]     t_prod_word;
    typedef logic signed [PAIR_W-1:0] t_pair_word;
    typedef logic signed [SUM_W-1:0]  t_sum_word;

    typedef t_word      t_vec  [DIM];
    typedef t_word      t_mat  [ENTRIES];
    typedef t_prod_word t_prod [DIM][DIM];
    typedef t_pair_word t_pair [DIM][DIM/2];
    typedef t_sum_word  t_sum  [DIM];

endpackage

// File: src/vmt_matrix.sv
// matrix entry registers, column-major, reset to identity
module vmt_matrix import vmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_idx,
    input  t_word            i_data,
    output t_mat             o_mat
);

    localparam t_word ONE = t_word'(1) <<< FRAC_BITS;

    t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_mat[i] <= (i % (DIM + 1) == 0) ? ONE : '0;
            end
        end else if (i_we) begin
            r_mat[i_idx] <= i_data;
        end
    end

    assign o_mat = r_mat;

endmodule

// File: src/vmt_product.sv
// first pipeline stage: sixteen full-width entry-by-component products
module vmt_product import vmt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_vec  i_vec,
    input  t_mat  i_mat,
    input  logic  i_adv,
    output logic  o_adv,
    output logic  o_vld,
    output t_prod o_prod
);

    logic  r_vld;
    t_prod r_prod;
    logic  adv;

    assign adv = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    // matrix is sampled at the accepting edge, so loads stay in order
    always_ff @(posedge i_clk) begin
        if (adv && i_vld) begin
            for (int r = 0; r < DIM; r++) begin
                for (int k = 0; k < DIM; k++) begin
                    r_prod[r][k] <= PW'(i_mat[k*DIM + r]) * PW'(i_vec[k]);
                end
            end
        end
    end

    assign o_adv  = adv;
    assign o_vld  = r_vld;
    assign o_prod = r_prod;

endmodule

// File: src/vmt_reduce.sv
// two adder-tree stages: product pairs, then full row sums
module vmt_reduce import vmt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_prod i_prod,
    input  logic  i_adv,
    output logic  o_adv,
    output logic  o_vld,
    output t_sum  o_sum
);

    logic  r_vld_a;
    logic  r_vld_b;
    t_pair r_pair;
    t_sum  r_sum;
    logic  adv_a;
    logic  adv_b;

    assign adv_b = !r_vld_b || i_adv;
    assign adv_a = !r_vld_a || adv_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (adv_a) begin
                r_vld_a <= i_vld;
            end
            if (adv_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_vld) begin
            for (int r = 0; r < DIM; r++) begin
                for (int j = 0; j < DIM/2; j++) begin
                    r_pair[r][j] <= PAIR_W'(i_prod[r][2*j]) + PAIR_W'(i_prod[r][2*j+1]);
                end
            end
        end
        if (adv_b && r_vld_a) begin
            for (int r = 0; r < DIM; r++) begin
                r_sum[r] <= SUM_W'(r_pair[r][0]) + SUM_W'(r_pair[r][1]);
            end
        end
    end

    assign o_adv = adv_a;
    assign o_vld = r_vld_b;
    assign o_sum = r_sum;

endmodule

// File: src/vmt_clip.sv
// last stage: drop fraction bits, saturate to 32 bits, output register
module vmt_clip import vmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_sum  i_sum,
    input  logic  i_stall,
    output logic  o_adv,
    output logic  o_vld,
    output t_vec  o_vec,
    output logic  o_sat
);

    localparam t_word MAX_W = {1'b0, {(DW-1){1'b1}}};
    localparam t_word MIN_W = {1'b1, {(DW-1){1'b0}}};

    logic      r_vld;
    t_vec      r_vec;
    logic      r_sat;
    t_vec      n_vec;
    logic      n_sat;
    t_sum_word shifted [DIM];
    logic      adv;

    assign adv = !r_vld || !i_stall;

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            // arithmetic shift rounds toward minus infinity
            shifted[r] = i_sum[r] >>> FRAC_BITS;
            if (shifted[r][SUM_W-1:DW-1] == '0 || shifted[r][SUM_W-1:DW-1] == '1) begin
                n_vec[r] = shifted[r][DW-1:0];
            end else begin
                n_vec[r] = shifted[r][SUM_W-1] ? MIN_W : MAX_W;
                n_sat    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_vld) begin
            r_vec <= n_vec;
            r_sat <= n_sat;
        end
    end

    assign o_adv = adv;
    assign o_vld = r_vld;
    assign o_vec = r_vec;
    assign o_sat = r_sat;

endmodule

// File: src/vec4_matrix_transform.sv
// top level of the 4x4 matrix times 4-vector transform engine
// Holds a 4x4 signed fixed-point matrix (column-major, entry col*4+row) that
// resets to identity. A load transaction (i_func = 0) writes one entry and
// produces nothing; the next transaction already sees the new value. A
// transform transaction (i_func = 1) yields out_x..out_w = matrix rows dot
// vector: exact 66-bit sums of the four products, arithmetic shift right by
// FRAC_BITS (floor), saturated to 32 bits, with o_saturated set if any
// component clipped. One transaction is taken every cycle unless o_stall is
// high; a result reaches the outputs after passing four register stages
// (product registers, two adder-tree levels, clip and output register).
// Back-pressure on the output stalls the input only once all four stages
// hold results.
module vec4_matrix_transform import vmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic signed [DW-1:0] i_coefficient,
    input  logic signed [DW-1:0] i_vec_x,
    input  logic signed [DW-1:0] i_vec_y,
    input  logic signed [DW-1:0] i_vec_z,
    input  logic signed [DW-1:0] i_vec_w,
    output logic             o_valid,
    input  logic             i_stall,
    output logic signed [DW-1:0] o_out_x,
    output logic signed [DW-1:0] o_out_y,
    output logic signed [DW-1:0] o_out_z,
    output logic signed [DW-1:0] o_out_w,
    output logic             o_saturated
);

    t_mat  mat;
    t_vec  vec_in;
    t_vec  vec_out;
    t_prod prod;
    t_sum  sum;
    logic  accept;
    logic  adv_prod;
    logic  adv_red;
    logic  adv_clip;
    logic  vld_prod;
    logic  vld_red;

    assign o_stall   = !adv_prod;
    assign accept    = i_valid && adv_prod;
    assign vec_in[0] = i_vec_x;
    assign vec_in[1] = i_vec_y;
    assign vec_in[2] = i_vec_z;
    assign vec_in[3] = i_vec_w;

    vmt_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && i_func == FUNC_LOAD),
        .i_idx   (i_entry_index),
        .i_data  (i_coefficient),
        .o_mat   (mat)
    );

    vmt_product u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_valid && i_func == FUNC_TRANSFORM),
        .i_vec   (vec_in),
        .i_mat   (mat),
        .i_adv   (adv_red),
        .o_adv   (adv_prod),
        .o_vld   (vld_prod),
        .o_prod  (prod)
    );

    vmt_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_prod),
        .i_prod  (prod),
        .i_adv   (adv_clip),
        .o_adv   (adv_red),
        .o_vld   (vld_red),
        .o_sum   (sum)
    );

    vmt_clip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_red),
        .i_sum   (sum),
        .i_stall (i_stall),
        .o_adv   (adv_clip),
        .o_vld   (o_valid),
        .o_vec   (vec_out),
        .o_sat   (o_saturated)
    );

    assign o_out_x = vec_out[0];
    assign o_out_y = vec_out[1];
    assign o_out_z = vec_out[2];
    assign o_out_w = vec_out[3];

endmodule
